// ===== rtl/ofkc_pkg.sv =====
// ----------------------------------------------------------------------------
// ofkc_pkg
// Types and codes shared by the optimal replacement cache and its checker.
// ----------------------------------------------------------------------------
package ofkc_pkg;

   localparam int PAGE_W = 32;
   localparam int CAP_W  = 5;
   localparam int STAT_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_ACCESS = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STAT_W-1:0] ST_FILL   = 3'd1;
   localparam logic [STAT_W-1:0] ST_EVICT  = 3'd2;
   localparam logic [STAT_W-1:0] ST_APPEND = 3'd3;
   localparam logic [STAT_W-1:0] ST_DROP   = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

// ===== rtl/ofkc_ram.sv =====
// ----------------------------------------------------------------------------
// ofkc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ofkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/optimal_future_knowledge_cache_unit.sv =====
// ----------------------------------------------------------------------------
// optimal_future_knowledge_cache_unit
// Optimal (farthest next use) replacement cache with a stored future trace.
// ----------------------------------------------------------------------------
// append: result registered in the cycle after the beat is taken
// access: a way scan, then a trace scan that stops at the first match,
//   each reading one entry per cycle through one shared page comparator
// one item at a time; req_ready is low until the lookup is done and the result register is free
// synchronous reset clears control state only, the stores need no clearing
// ----------------------------------------------------------------------------
module optimal_future_knowledge_cache_unit #(
   parameter int TRACE_DEPTH = 4096,
   parameter int WAYS        = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ofkc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ofkc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ofkc_pkg::CAP_W-1:0]         csr_data
);

   localparam int TAW   = $clog2(TRACE_DEPTH);
   localparam int CW    = $clog2(TRACE_DEPTH + 1);
   localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCW   = $clog2(WAYS + 1);
   localparam int PW    = ofkc_pkg::PAGE_W;
   localparam int ENT_W = PW + 2 * CW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WAYS   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_TRACE  = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;

   localparam logic [CW-1:0] NEVER = '1;

   logic [2:0]                  state_ff, state_in;
   logic [ofkc_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [CW-1:0]               trace_len_ff, trace_len_in;
   logic [CW-1:0]               acc_cnt_ff, acc_cnt_in;
   logic [WAYS-1:0]             valid_ff, valid_in;
   logic [PW-1:0]               pg_ff, pg_in;
   logic [WCW-1:0]              wcnt_ff, wcnt_in;
   logic [WIW-1:0]              wpidx_ff, wpidx_in;
   logic [CW-1:0]               tcnt_ff, tcnt_in;
   logic [CW-1:0]               tpidx_ff, tpidx_in;
   logic                        pend_ff, pend_in;
   logic [WCW-1:0]              used_ff, used_in;
   logic                        hit_fnd_ff, hit_fnd_in;
   logic [WIW-1:0]              hit_way_ff, hit_way_in;
   logic                        vic_fnd_ff, vic_fnd_in;
   logic [WIW-1:0]              vic_way_ff, vic_way_in;
   logic [CW-1:0]               vnext_ff, vnext_in;
   logic [CW-1:0]               vtouch_ff, vtouch_in;
   logic                        free_fnd_ff, free_fnd_in;
   logic [WIW-1:0]              free_way_ff, free_way_in;
   logic [WIW-1:0]              tgt_ff, tgt_in;
   logic [CW-1:0]               next_ff, next_in;
   ofkc_pkg::rsp_type           res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ofkc_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic                        trace_wr;
   logic [TAW-1:0]              trace_rd_addr;
   logic [PW-1:0]               trace_rd_data;
   logic                        ent_wr;
   logic [ENT_W-1:0]            ent_wr_data;
   logic [ENT_W-1:0]            ent_rd_data;
   logic [PW-1:0]               ent_page;
   logic [CW-1:0]               ent_next;
   logic [CW-1:0]               ent_touch;
   logic [PW-1:0]               cmp_a;
   logic                        page_eq;
   logic [WCW-1:0]              eff_cap;
   logic                        evict;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign {ent_page, ent_next, ent_touch} = ent_rd_data;

   // the one page comparator, shared by the way scan and the trace scan
   assign cmp_a   = (state_ff == S_WAYS) ? ent_page : trace_rd_data;
   assign page_eq = (cmp_a == pg_ff);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = WCW'(1);
      end else if (32'(cap_ff) > 32'(WAYS)) begin
         eff_cap = WCW'(WAYS);
      end else begin
         eff_cap = WCW'(cap_ff);
      end
   end

   assign evict = !hit_fnd_ff && vic_fnd_ff && (used_ff >= eff_cap);

   ofkc_ram #(
      .WIDTH (PW),
      .DEPTH (TRACE_DEPTH)
   ) u_trace_ram (
      .clock   (clock),
      .wr_en   (trace_wr),
      .wr_addr (trace_len_ff[TAW-1:0]),
      .wr_data (req_data.page),
      .rd_addr (trace_rd_addr),
      .rd_data (trace_rd_data)
   );

   ofkc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (WAYS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr),
      .wr_addr (tgt_ff),
      .wr_data (ent_wr_data),
      .rd_addr (wcnt_ff[WIW-1:0]),
      .rd_data (ent_rd_data)
   );

   assign trace_wr      = req_fire && (req_data.operation == ofkc_pkg::OP_APPEND)
                          && (trace_len_ff < CW'(TRACE_DEPTH));
   assign trace_rd_addr = tcnt_ff[TAW-1:0];
   assign ent_wr        = (state_ff == S_WRITE);
   assign ent_wr_data   = {pg_ff, next_ff, acc_cnt_ff};

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      trace_len_in = trace_len_ff;
      acc_cnt_in   = acc_cnt_ff;
      valid_in     = valid_ff;
      pg_in        = pg_ff;
      wcnt_in      = wcnt_ff;
      wpidx_in     = wpidx_ff;
      tcnt_in      = tcnt_ff;
      tpidx_in     = tpidx_ff;
      pend_in      = pend_ff;
      used_in      = used_ff;
      hit_fnd_in   = hit_fnd_ff;
      hit_way_in   = hit_way_ff;
      vic_fnd_in   = vic_fnd_ff;
      vic_way_in   = vic_way_ff;
      vnext_in     = vnext_ff;
      vtouch_in    = vtouch_ff;
      free_fnd_in  = free_fnd_ff;
      free_way_in  = free_way_ff;
      tgt_in       = tgt_ff;
      next_in      = next_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         cap_in = csr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == ofkc_pkg::OP_APPEND) begin
                  rsp_valid_in     = 1'b1;
                  rsp_data_in.hit  = 1'b0;
                  if (trace_len_ff < CW'(TRACE_DEPTH)) begin
                     trace_len_in       = trace_len_ff + CW'(1);
                     rsp_data_in.status = ofkc_pkg::ST_APPEND;
                  end else begin
                     rsp_data_in.status = ofkc_pkg::ST_DROP;
                  end
               end else begin
                  pg_in       = req_data.page;
                  if (acc_cnt_ff < CW'(TRACE_DEPTH)) begin
                     acc_cnt_in = acc_cnt_ff + CW'(1);
                  end
                  wcnt_in     = '0;
                  pend_in     = 1'b0;
                  used_in     = '0;
                  hit_fnd_in  = 1'b0;
                  vic_fnd_in  = 1'b0;
                  free_fnd_in = 1'b0;
                  state_in    = S_WAYS;
               end
            end
         end
         S_WAYS: begin
            // issue one entry read per cycle, evaluate the one read last cycle
            if (wcnt_ff != WCW'(WAYS)) begin
               wcnt_in  = wcnt_ff + WCW'(1);
               wpidx_in = wcnt_ff[WIW-1:0];
               pend_in  = 1'b1;
            end else begin
               pend_in  = 1'b0;
            end
            if (pend_ff) begin
               if (valid_ff[wpidx_ff]) begin
                  used_in = used_ff + WCW'(1);
                  if (!hit_fnd_ff && page_eq) begin
                     hit_fnd_in = 1'b1;
                     hit_way_in = wpidx_ff;
                  end
                  if (!vic_fnd_ff || (ent_next > vnext_ff) ||
                      ((ent_next == vnext_ff) && (ent_touch < vtouch_ff))) begin
                     vic_fnd_in = 1'b1;
                     vic_way_in = wpidx_ff;
                     vnext_in   = ent_next;
                     vtouch_in  = ent_touch;
                  end
               end else if (!free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_way_in = wpidx_ff;
               end
            end
            if ((wcnt_ff == WCW'(WAYS)) && !pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (hit_fnd_ff) begin
               tgt_in = hit_way_ff;
               res_in = '{hit: 1'b1, status: ofkc_pkg::ST_HIT};
            end else if (evict) begin
               // fill goes to the lowest free way once the victim is dropped
               if (free_fnd_ff && (free_way_ff < vic_way_ff)) begin
                  tgt_in = free_way_ff;
               end else begin
                  tgt_in = vic_way_ff;
               end
               res_in = '{hit: 1'b0, status: ofkc_pkg::ST_EVICT};
            end else begin
               tgt_in = free_way_ff;
               res_in = '{hit: 1'b0, status: ofkc_pkg::ST_FILL};
            end
            if (evict) begin
               valid_in[vic_way_ff] = 1'b0;
            end
            valid_in[tgt_in] = 1'b1;
            tcnt_in  = acc_cnt_ff;
            next_in  = NEVER;
            pend_in  = 1'b0;
            state_in = S_TRACE;
         end
         S_TRACE: begin
            if (tcnt_ff < trace_len_ff) begin
               tcnt_in  = tcnt_ff + CW'(1);
               tpidx_in = tcnt_ff;
               pend_in  = 1'b1;
            end else begin
               pend_in  = 1'b0;
            end
            if (pend_ff && page_eq) begin
               next_in  = tpidx_ff;
               pend_in  = 1'b0;
               state_in = S_WRITE;
            end else if (!(tcnt_ff < trace_len_ff) && !pend_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= ofkc_pkg::CAP_RESET;
         trace_len_ff <= '0;
         acc_cnt_ff   <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         trace_len_ff <= trace_len_in;
         acc_cnt_ff   <= acc_cnt_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pg_ff       <= pg_in;
      wcnt_ff     <= wcnt_in;
      wpidx_ff    <= wpidx_in;
      tcnt_ff     <= tcnt_in;
      tpidx_ff    <= tpidx_in;
      used_ff     <= used_in;
      hit_fnd_ff  <= hit_fnd_in;
      hit_way_ff  <= hit_way_in;
      vic_fnd_ff  <= vic_fnd_in;
      vic_way_ff  <= vic_way_in;
      vnext_ff    <= vnext_in;
      vtouch_ff   <= vtouch_in;
      free_fnd_ff <= free_fnd_in;
      free_way_ff <= free_way_in;
      tgt_ff      <= tgt_in;
      next_ff     <= next_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/ofkc_checker.sv =====
// ----------------------------------------------------------------------------
// ofkc_checker
// Port level checks for the optimal replacement cache, bound to the top level.
// ----------------------------------------------------------------------------
module ofkc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ofkc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ofkc_pkg::rsp_type rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // an append answers in the next cycle with an append status
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation == ofkc_pkg::OP_APPEND)
      |=> rsp_valid && !rsp_data.hit &&
          ((rsp_data.status == ofkc_pkg::ST_APPEND) ||
           (rsp_data.status == ofkc_pkg::ST_DROP)))
      else $error("append result missing or wrong");

   // an access keeps the block busy and shows no result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation == ofkc_pkg::OP_ACCESS)
      |=> !rsp_valid && !req_ready)
      else $error("access did not start the lookup");

   // hit flag agrees with the status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit == (rsp_data.status == ofkc_pkg::ST_HIT)))
      else $error("hit flag and status disagree");

endmodule

bind optimal_future_knowledge_cache_unit ofkc_checker u_ofkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/optimal_future_knowledge_cache_unit_test.sv =====
// ----------------------------------------------------------------------------
// optimal_future_knowledge_cache_unit_test
// Self-checking bench for the farthest-next-use replacement cache. A local
// copy of the trace, the ways and the capacity register predicts hit and
// status for every accepted request. Stimulus covers directed corner cases,
// trace-following random rounds under several capacities and idle mixes and
// a long response hold-off.
// ----------------------------------------------------------------------------
module optimal_future_knowledge_cache_unit_test;

   localparam int TRACE_DEPTH = 4096;
   localparam int WAYS        = 16;
   localparam int IDX_W       = 13;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT       = 2000000;
   localparam logic [IDX_W-1:0] NO_NEXT_USE = '1;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   ofkc_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   ofkc_pkg::rsp_type          rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [ofkc_pkg::CAP_W-1:0] csr_data;

   // local copy of the cache state
   logic [ofkc_pkg::PAGE_W-1:0] trace_mem [TRACE_DEPTH];
   int                          trace_len = 0;
   int                          access_cnt = 0;
   logic                        way_valid [WAYS] = '{default: 1'b0};
   logic [ofkc_pkg::PAGE_W-1:0] way_page [WAYS];
   logic [IDX_W-1:0]            way_next [WAYS];
   logic [IDX_W-1:0]            way_touch [WAYS];
   logic [ofkc_pkg::CAP_W-1:0]  cap_reg = ofkc_pkg::CAP_RESET;

   ofkc_pkg::rsp_type           hit_status_q [$];
   int                          mismatch_count = 0;
   int                          cycle_count = 0;

   // stimulus side view of the trace
   logic [ofkc_pkg::PAGE_W-1:0] trace_plan [$];
   int                          access_sent = 0;
   int                          items_sent = 0;

   int                          req_idle_pct = 0;
   int                          rsp_idle_pct = 0;
   int                          hold_asks = 0;
   int                          holds_served = 0;

   optimal_future_knowledge_cache_unit #(
      .TRACE_DEPTH (TRACE_DEPTH),
      .WAYS        (WAYS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [IDX_W-1:0] next_reference(logic [ofkc_pkg::PAGE_W-1:0] pg);
      int i;
      for (i = access_cnt; i < trace_len; i++) begin
         if (trace_mem[i] == pg) return IDX_W'(i);
      end
      return NO_NEXT_USE;
   endfunction

   function automatic ofkc_pkg::rsp_type min_cache_step(ofkc_pkg::req_type rq);
      ofkc_pkg::rsp_type r;
      int      w;
      int      hit_way;
      int      victim;
      int      used;
      int      limit;
      r.hit = 1'b0;
      if (rq.operation == ofkc_pkg::OP_APPEND) begin
         if (trace_len < TRACE_DEPTH) begin
            trace_mem[trace_len] = rq.page;
            trace_len++;
            r.status = ofkc_pkg::ST_APPEND;
         end else begin
            r.status = ofkc_pkg::ST_DROP;
         end
         return r;
      end
      if (access_cnt < TRACE_DEPTH) access_cnt++;
      hit_way = -1;
      used = 0;
      for (w = 0; w < WAYS; w++) begin
         if (way_valid[w]) begin
            used++;
            if (hit_way < 0 && way_page[w] == rq.page) hit_way = w;
         end
      end
      if (hit_way >= 0) begin
         way_next[hit_way] = next_reference(rq.page);
         way_touch[hit_way] = IDX_W'(access_cnt);
         r.hit = 1'b1;
         r.status = ofkc_pkg::ST_HIT;
         return r;
      end
      limit = (cap_reg == 0) ? 1 : (cap_reg > WAYS) ? WAYS : int'(cap_reg);
      r.status = ofkc_pkg::ST_FILL;
      if (used >= limit) begin
         victim = -1;
         // farthest next use wins, earliest touch breaks ties, lowest way last
         for (w = 0; w < WAYS; w++) begin
            if (!way_valid[w]) continue;
            if (victim < 0 || way_next[w] > way_next[victim] ||
                (way_next[w] == way_next[victim] && way_touch[w] < way_touch[victim]))
               victim = w;
         end
         if (victim >= 0) begin
            way_valid[victim] = 1'b0;
            r.status = ofkc_pkg::ST_EVICT;
         end
      end
      for (w = 0; w < WAYS; w++) begin
         if (!way_valid[w]) begin
            way_valid[w] = 1'b1;
            way_page[w] = rq.page;
            way_next[w] = next_reference(rq.page);
            way_touch[w] = IDX_W'(access_cnt);
            break;
         end
      end
      return r;
   endfunction

   // prediction on each request beat, comparison on each response beat
   always @(posedge clock) begin
      ofkc_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) cap_reg <= csr_data;
         if (req_valid && req_ready)
            hit_status_q.insert(hit_status_q.size(), min_cache_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (hit_status_q.size() == 0) begin
               $error("unexpected response: hit %0d, status %0d",
                      rsp_data.hit, rsp_data.status);
               mismatch_count++;
            end else begin
               want = hit_status_q.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                  mismatch_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_asks) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic int idle_gap(int pct);
      int n;
      n = 0;
      while (n < 40 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   task automatic send_item(input logic op, input logic [ofkc_pkg::PAGE_W-1:0] pg);
      int gap;
      gap = idle_gap(req_idle_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, page: pg};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == ofkc_pkg::OP_APPEND) begin
         if (trace_plan.size() < TRACE_DEPTH) trace_plan.insert(trace_plan.size(), pg);
      end else begin
         access_sent++;
      end
      items_sent++;
   endtask

   // stop offering and wait for every outstanding response, ends on a falling edge
   task automatic wait_responses;
      @(negedge clock);
      req_valid <= 1'b0;
      while (hit_status_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [ofkc_pkg::CAP_W-1:0] cap);
      wait_responses();
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases;
      req_idle_pct = 15;
      rsp_idle_pct = 15;
      send_item(ofkc_pkg::OP_APPEND, 32'h0000_0000);
      send_item(ofkc_pkg::OP_APPEND, 32'hFFFF_FFFF);
      send_item(ofkc_pkg::OP_APPEND, 32'h0000_0000);
      send_item(ofkc_pkg::OP_APPEND, 32'h5A5A_5A5A);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0000);
      send_item(ofkc_pkg::OP_ACCESS, 32'hFFFF_FFFF);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0000);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0000);
      send_item(ofkc_pkg::OP_ACCESS, 32'hA5A5_A5A5);
      // capacity lowered below occupancy: one victim per miss
      set_capacity(5'd1);
      send_item(ofkc_pkg::OP_ACCESS, 32'h5A5A_5A5A);
      send_item(ofkc_pkg::OP_ACCESS, 32'h1234_5678);
      set_capacity(5'd0);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0000);
      send_item(ofkc_pkg::OP_ACCESS, 32'h8765_4321);
      set_capacity(5'd31);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0001);
      send_item(ofkc_pkg::OP_ACCESS, 32'h8000_0000);
      send_item(ofkc_pkg::OP_ACCESS, 32'h7FFF_FFFF);
      send_item(ofkc_pkg::OP_ACCESS, 32'hFFFF_FFFE);
      set_capacity(5'd17);
      send_item(ofkc_pkg::OP_ACCESS, 32'h0000_0002);
      send_item(ofkc_pkg::OP_ACCESS, 32'h8000_0000);
      set_capacity(5'd16);
   endtask

   // append a chunk of the future trace, then mostly walk it in order
   task automatic random_round;
      logic [ofkc_pkg::PAGE_W-1:0] pool [8];
      logic [ofkc_pkg::PAGE_W-1:0] pg;
      logic [ofkc_pkg::CAP_W-1:0]  cap;
      int                          pool_n;
      int                          n;
      int                          k;
      int                          pick;
      case ($urandom_range(0, 7))
         0: cap = 5'd0;
         1: cap = 5'd31;
         2: cap = ofkc_pkg::CAP_W'($urandom_range(17, 30));
         3, 4: cap = ofkc_pkg::CAP_W'($urandom_range(7, 16));
         default: cap = ofkc_pkg::CAP_W'($urandom_range(1, 6));
      endcase
      set_capacity(cap);
      pool_n = $urandom_range(2, 8);
      for (k = 0; k < pool_n; k++) begin
         pick = $urandom_range(0, 9);
         pool[k] = (pick == 0) ? '0 : (pick == 1) ? '1 : ofkc_pkg::PAGE_W'($urandom());
      end
      n = $urandom_range(4, 12);
      for (k = 0; k < n; k++)
         send_item(ofkc_pkg::OP_APPEND, pool[$urandom_range(0, pool_n - 1)]);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(ofkc_pkg::OP_APPEND, ofkc_pkg::PAGE_W'($urandom()));
         pick = $urandom_range(0, 19);
         if (pick < 15 && access_sent < trace_plan.size()) pg = trace_plan[access_sent];
         else if (pick < 18) pg = pool[$urandom_range(0, pool_n - 1)];
         else pg = ofkc_pkg::PAGE_W'($urandom());
         send_item(ofkc_pkg::OP_ACCESS, pg);
      end
   endtask

   task automatic test_random_traffic;
      int mode;
      int start;
      for (mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 85 : 0;
         rsp_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 0;
         start = items_sent;
         while (items_sent - start < 30) random_round();
      end
   endtask

   // long response hold-off while requests keep coming, then a full drain
   task automatic test_backpressure;
      int k;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_capacity(5'd3);
      @(posedge clock);
      hold_asks++;
      for (k = 0; k < 10; k++) begin
         if (k % 3 == 0)
            send_item(ofkc_pkg::OP_APPEND, ofkc_pkg::PAGE_W'($urandom_range(0, 3)));
         else
            send_item(ofkc_pkg::OP_ACCESS, ofkc_pkg::PAGE_W'($urandom_range(0, 5)));
      end
      wait_responses();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      test_backpressure();
      wait_responses();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
